@@ rtl/hdcsd_pkg.sv @@
// ----------------------------------------------------------------------------
// hdcsd_pkg
// Shared types and constants for the header-checked stream decryptor.
// ----------------------------------------------------------------------------
package hdcsd_pkg;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [30:0] blob_length;
    logic        last_in;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last_out;
  } out_beat_t;

  localparam int unsigned MAX_RESULTS = 4;

  // all results caused by one input beat, beats[0] goes out first
  typedef struct packed {
    logic [2:0]                   count;
    out_beat_t [MAX_RESULTS-1:0]  beats;
  } res_group_t;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [31:0] stream_salt;
  } cfg_t;

  typedef enum logic [2:0] {
    PH_MAGIC,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_PASS,
    PH_DROP
  } phase_t;

  localparam logic [1:0] ST_DECRYPT = 2'd0;
  localparam logic [1:0] ST_PASS    = 2'd1;
  localparam logic [1:0] ST_FAIL    = 2'd2;

  localparam logic REG_MAGIC = 1'b0;
  localparam logic REG_SALT  = 1'b1;

  localparam logic [31:0] MAGIC_RESET = 32'h5259_4A53;
  localparam logic [31:0] SALT_RESET  = 32'h6A5C_4E31;

  localparam logic [30:0] HEADER_BYTES    = 31'd8;
  localparam logic [30:0] LAST_MAGIC_IDX  = 31'd3;
  localparam logic [30:0] LAST_HEADER_IDX = 31'd7;
  localparam logic [30:0] COUNT_MAX       = 31'h7FFF_FFFF;

  function automatic out_beat_t mk_beat(input logic [7:0] b, input logic [1:0] st,
                                        input logic lst);
    out_beat_t r;
    r.out_byte = b;
    r.status   = st;
    r.last_out = lst;
    return r;
  endfunction

endpackage

@@ rtl/hdcsd_cfg.sv @@
// ----------------------------------------------------------------------------
// hdcsd_cfg
// APB register file: magic word and keystream salt.
// ----------------------------------------------------------------------------
module hdcsd_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output hdcsd_pkg::cfg_t    cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_word  <= hdcsd_pkg::MAGIC_RESET;
      cfg.stream_salt <= hdcsd_pkg::SALT_RESET;
    end else if (wr_en) begin
      if (paddr[2] == hdcsd_pkg::REG_MAGIC) begin
        cfg.magic_word <= pwdata;
      end else begin
        cfg.stream_salt <= pwdata;
      end
    end
  end

  assign prdata = (paddr[2] == hdcsd_pkg::REG_SALT) ? cfg.stream_salt : cfg.magic_word;

endmodule

@@ rtl/hdcsd_core.sv @@
// ----------------------------------------------------------------------------
// hdcsd_core
// Per-blob state and the single-pass step: header check, length check,
// keystream update and result generation for one input beat.
// ----------------------------------------------------------------------------
module hdcsd_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  hdcsd_pkg::in_beat_t   item,
  input  hdcsd_pkg::cfg_t       cfg,
  output hdcsd_pkg::res_group_t group
);

  hdcsd_pkg::phase_t phase, phase_next, cur_phase;
  logic [30:0] byte_count, byte_count_next;
  logic [31:0] header_hold, header_hold_next;
  logic [31:0] payload_length, payload_length_next;
  logic [31:0] key_accumulator, key_accumulator_next;

  logic [31:0] hold_shift, len_shift, blen_room, idx, acc_step;
  logic        short_blob, magic_done, header_done, magic_ok, len_bad, fin;

  assign hold_shift  = {header_hold[23:0], item.data_byte};
  assign len_shift   = {payload_length[23:0], item.data_byte};
  assign blen_room   = {1'b0, item.blob_length} - {1'b0, hdcsd_pkg::HEADER_BYTES};
  assign len_bad     = (len_shift == 32'd0) || (len_shift > blen_room);
  assign idx         = {1'b0, byte_count} - {1'b0, hdcsd_pkg::HEADER_BYTES};
  assign fin         = (idx == payload_length - 32'd1);
  // acc * 33 as shift-add
  assign acc_step    = ((key_accumulator << 5) + key_accumulator) ^ (idx + payload_length);
  assign magic_ok    = (hold_shift == cfg.magic_word);
  assign magic_done  = (byte_count == hdcsd_pkg::LAST_MAGIC_IDX);
  assign header_done = (byte_count >= hdcsd_pkg::LAST_HEADER_IDX);

  // short blobs are decided on byte 0 only
  assign short_blob = (phase == hdcsd_pkg::PH_MAGIC) && (byte_count == 31'd0) &&
                      (item.blob_length < hdcsd_pkg::HEADER_BYTES);
  assign cur_phase  = short_blob ? hdcsd_pkg::PH_PASS : phase;

  // next state
  always_comb begin
    phase_next = cur_phase;
    case (cur_phase)
      hdcsd_pkg::PH_MAGIC: begin
        if (magic_done) begin
          phase_next = magic_ok ? hdcsd_pkg::PH_LENGTH : hdcsd_pkg::PH_PASS;
        end
      end
      hdcsd_pkg::PH_LENGTH: begin
        if (header_done) begin
          phase_next = len_bad ? hdcsd_pkg::PH_DROP : hdcsd_pkg::PH_PAYLOAD;
        end
      end
      hdcsd_pkg::PH_PAYLOAD: begin
        if (fin) begin
          phase_next = hdcsd_pkg::PH_DROP;
        end
      end
      default: ;
    endcase
    if (item.last_in) begin
      phase_next = hdcsd_pkg::PH_MAGIC;
    end
  end

  // results for this beat
  always_comb begin
    group = '0;
    case (cur_phase)
      hdcsd_pkg::PH_MAGIC: begin
        if (magic_done) begin
          if (!magic_ok) begin
            group.count    = 3'd4;
            group.beats[0] = hdcsd_pkg::mk_beat(hold_shift[31:24], hdcsd_pkg::ST_PASS, 1'b0);
            group.beats[1] = hdcsd_pkg::mk_beat(hold_shift[23:16], hdcsd_pkg::ST_PASS, 1'b0);
            group.beats[2] = hdcsd_pkg::mk_beat(hold_shift[15:8], hdcsd_pkg::ST_PASS, 1'b0);
            group.beats[3] = hdcsd_pkg::mk_beat(hold_shift[7:0], hdcsd_pkg::ST_PASS,
                                                item.last_in);
          end
        end else if (item.last_in) begin
          // blob ended inside the magic bytes: flush what is held
          case (byte_count[1:0])
            2'd1: begin
              group.count    = 3'd2;
              group.beats[0] = hdcsd_pkg::mk_beat(header_hold[7:0], hdcsd_pkg::ST_PASS, 1'b0);
              group.beats[1] = hdcsd_pkg::mk_beat(item.data_byte, hdcsd_pkg::ST_PASS, 1'b1);
            end
            2'd2: begin
              group.count    = 3'd3;
              group.beats[0] = hdcsd_pkg::mk_beat(header_hold[15:8], hdcsd_pkg::ST_PASS, 1'b0);
              group.beats[1] = hdcsd_pkg::mk_beat(header_hold[7:0], hdcsd_pkg::ST_PASS, 1'b0);
              group.beats[2] = hdcsd_pkg::mk_beat(item.data_byte, hdcsd_pkg::ST_PASS, 1'b1);
            end
            default: begin
              group.count    = 3'd1;
              group.beats[0] = hdcsd_pkg::mk_beat(item.data_byte, hdcsd_pkg::ST_PASS, 1'b1);
            end
          endcase
        end
      end
      hdcsd_pkg::PH_LENGTH: begin
        if (header_done ? len_bad : item.last_in) begin
          group.count    = 3'd1;
          group.beats[0] = hdcsd_pkg::mk_beat(8'h00, hdcsd_pkg::ST_FAIL, 1'b1);
        end
      end
      hdcsd_pkg::PH_PAYLOAD: begin
        group.count    = 3'd1;
        group.beats[0] = hdcsd_pkg::mk_beat(item.data_byte ^ acc_step[7:0],
                                            hdcsd_pkg::ST_DECRYPT, fin || item.last_in);
      end
      hdcsd_pkg::PH_PASS: begin
        group.count    = 3'd1;
        group.beats[0] = hdcsd_pkg::mk_beat(item.data_byte, hdcsd_pkg::ST_PASS, item.last_in);
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    header_hold_next     = header_hold;
    payload_length_next  = payload_length;
    key_accumulator_next = key_accumulator;
    byte_count_next      = byte_count;
    if (cur_phase == hdcsd_pkg::PH_MAGIC) begin
      header_hold_next = hold_shift;
    end
    if (cur_phase == hdcsd_pkg::PH_LENGTH) begin
      payload_length_next = len_shift;
      if (header_done && !len_bad) begin
        key_accumulator_next = cfg.stream_salt ^ len_shift;
      end
    end
    if (cur_phase == hdcsd_pkg::PH_PAYLOAD) begin
      key_accumulator_next = acc_step;
    end
    if (byte_count != hdcsd_pkg::COUNT_MAX) begin
      byte_count_next = byte_count + 31'd1;
    end
    if (item.last_in) begin
      header_hold_next     = '0;
      payload_length_next  = '0;
      key_accumulator_next = '0;
      byte_count_next      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= hdcsd_pkg::PH_MAGIC;
      byte_count      <= '0;
      header_hold     <= '0;
      payload_length  <= '0;
      key_accumulator <= '0;
    end else if (fire) begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      header_hold     <= header_hold_next;
      payload_length  <= payload_length_next;
      key_accumulator <= key_accumulator_next;
    end
  end

endmodule

@@ rtl/hdcsd_obuf.sv @@
// ----------------------------------------------------------------------------
// hdcsd_obuf
// Result slot holding one beat's group of up to four results, drained one
// per cycle into the output register while the output is not stalled.
// ----------------------------------------------------------------------------
module hdcsd_obuf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hdcsd_pkg::res_group_t group,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hdcsd_pkg::out_beat_t  out_data
);

  hdcsd_pkg::out_beat_t [hdcsd_pkg::MAX_RESULTS-1:0] slot;
  logic [2:0] slot_cnt;
  logic [1:0] slot_ptr;
  logic       out_take, out_load, fire;

  assign out_take = out_valid && out_ready;
  assign out_load = (slot_cnt != 3'd0) && (!out_valid || out_take);
  // slot frees up when its last pending result moves out this cycle
  assign in_ready = (slot_cnt == 3'd0) || ((slot_cnt == 3'd1) && out_load);
  assign fire     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_cnt  <= '0;
      slot_ptr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        slot_cnt <= group.count;
        slot_ptr <= '0;
      end else if (out_load) begin
        slot_cnt <= slot_cnt - 3'd1;
        slot_ptr <= slot_ptr + 2'd1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      slot <= group.beats;
    end
    if (out_load) begin
      out_data <= slot[slot_ptr];
    end
  end

endmodule

@@ rtl/header_checked_stream_decryptor_unit.sv @@
// ----------------------------------------------------------------------------
// header_checked_stream_decryptor_unit
// Checks a blob's magic/length header and decrypts its payload bytewise.
// ----------------------------------------------------------------------------
// Usage:
//   item channel: one blob byte per beat with the blob length and a last flag.
//   result channel: decrypted (status 0), passed-through (status 1) or
//   length-failure (status 2) bytes, last_out on the final result of a blob.
//   APB port: register 0 magic word at 0x0, register 1 key salt at 0x4;
//   write only while the block is idle.
// Path: an item's results go into the result slot, then the output register.
// Throughput: one item per cycle while each item yields at most one result
//   and the output is not stalled; an item with more results (four on a
//   magic mismatch) holds the input: the output drains one result a cycle.
// Blobs shorter than the header pass through untouched; bytes after
//   the payload or after a failure produce nothing.
// Reset: synchronous, clears the blob state and result buffer and reloads
//   the default magic word and salt.
// Stall: a stalled output register keeps its result; one further item's
//   results are taken into the slot behind it, then item_ready drops.
// ----------------------------------------------------------------------------
module header_checked_stream_decryptor_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  hdcsd_pkg::in_beat_t  item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output hdcsd_pkg::out_beat_t result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  hdcsd_pkg::cfg_t       cfg;
  hdcsd_pkg::res_group_t group;
  logic                  fire;

  assign fire = item_valid && item_ready;

  hdcsd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hdcsd_core u_core (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .item  (item),
    .cfg   (cfg),
    .group (group)
  );

  hdcsd_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_valid),
    .in_ready  (item_ready),
    .group     (group),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .out_data  (result)
  );

endmodule

@@ rtl/hdcsd_checker.sv @@
// ----------------------------------------------------------------------------
// hdcsd_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module hdcsd_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 result_valid,
  input logic                 result_ready,
  input hdcsd_pkg::out_beat_t result
);

  // a stalled beat stays offered
  a_hold_valid : assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result beat dropped while stalled");

  a_hold_data : assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(result))
    else $error("result payload changed while stalled");

  // a failure result is a zero byte and closes the blob
  a_fail_form : assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == hdcsd_pkg::ST_FAIL |->
      result.out_byte == 8'h00 && result.last_out)
    else $error("malformed failure result");

  a_reset_empty : assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind header_checked_stream_decryptor_unit hdcsd_checker u_hdcsd_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

@@ sim/header_checked_stream_decryptor_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// header_checked_stream_decryptor_unit_test
// Streams blobs into the decryptor and checks every result beat against a
// local prediction. Blobs are short, pass-through, header-failing, mismatched,
// noisy and well-formed ones. The run goes through several magic/salt settings
// and several patterns of input gaps and output stalls.
// ----------------------------------------------------------------------------
module header_checked_stream_decryptor_unit_test;

  localparam logic [31:0] KEY_MULT = 32'd33;

  typedef struct {
    hdcsd_pkg::in_beat_t  beat;
    bit                   typed;
    hdcsd_pkg::out_beat_t want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_ready;
  hdcsd_pkg::in_beat_t  item = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  hdcsd_pkg::out_beat_t result;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [2:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  // local copy of the block's registers and blob state
  logic [31:0]          cfg_magic;
  logic [31:0]          cfg_salt;
  hdcsd_pkg::phase_t    blob_phase;
  logic [30:0]          blob_pos;
  logic [31:0]          magic_hold;
  logic [31:0]          body_length;
  logic [31:0]          keystream;

  hdcsd_pkg::out_beat_t beat_outs[$];
  hdcsd_pkg::out_beat_t pending_out_beats[$];
  dir_row_t             directed_rows[$];
  int                   fed_items = 0;
  int                   mismatches = 0;
  int                   send_idle_pct = 0;
  int                   stall_pct = 0;

  header_checked_stream_decryptor_unit DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk) result_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin : check_results
    hdcsd_pkg::out_beat_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_out_beats.size() == 0) begin
        $error("result beat %h with nothing expected", result);
        mismatches++;
      end else begin
        want = pending_out_beats.pop_front();
        if (result.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, result.out_byte);
          mismatches++;
        end
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          mismatches++;
        end
        if (result.last_out !== want.last_out) begin
          $error("last_out: expected %0d, got %0d", want.last_out, result.last_out);
          mismatches++;
        end
      end
    end
  end

  function automatic void clear_blob_state();
    blob_phase  = hdcsd_pkg::PH_MAGIC;
    blob_pos    = '0;
    magic_hold  = '0;
    body_length = '0;
    keystream   = '0;
  endfunction

  function automatic void note_out(logic [7:0] d, logic [1:0] st, logic lst);
    beat_outs.push_back(hdcsd_pkg::out_beat_t'({d, st, lst}));
  endfunction

  // Works out the result beats of one input beat into beat_outs.
  // Returns 1 when the beat is swallowed after a failure or after the payload.
  function automatic bit decrypt_beat(hdcsd_pkg::in_beat_t b);
    logic [31:0] room;
    logic [31:0] idx;
    bit          fin;
    bit          ignored;
    int          s;
    beat_outs.delete();
    ignored = (blob_phase == hdcsd_pkg::PH_DROP);
    if (blob_phase == hdcsd_pkg::PH_MAGIC && blob_pos == '0 &&
        b.blob_length < hdcsd_pkg::HEADER_BYTES)
      blob_phase = hdcsd_pkg::PH_PASS;
    case (blob_phase)
      hdcsd_pkg::PH_MAGIC: begin
        if (blob_pos == hdcsd_pkg::LAST_MAGIC_IDX) begin
          magic_hold = {magic_hold[23:0], b.data_byte};
          if (magic_hold == cfg_magic) begin
            blob_phase = hdcsd_pkg::PH_LENGTH;
          end else begin
            for (s = 3; s >= 0; s--)
              note_out(magic_hold[8*s +: 8], hdcsd_pkg::ST_PASS,
                       (s == 0) ? b.last_in : 1'b0);
            blob_phase = hdcsd_pkg::PH_PASS;
          end
        end else if (b.last_in) begin
          // early end: flush what was held, the current byte closes the blob
          for (s = int'(blob_pos[1:0]); s > 0; s--)
            note_out(magic_hold[8*(s-1) +: 8], hdcsd_pkg::ST_PASS, 1'b0);
          note_out(b.data_byte, hdcsd_pkg::ST_PASS, 1'b1);
        end else begin
          magic_hold = {magic_hold[23:0], b.data_byte};
        end
      end
      hdcsd_pkg::PH_LENGTH: begin
        body_length = {body_length[23:0], b.data_byte};
        if (blob_pos >= hdcsd_pkg::LAST_HEADER_IDX) begin
          room = {1'b0, b.blob_length} - {1'b0, hdcsd_pkg::HEADER_BYTES};
          if (body_length == '0 || body_length > room) begin
            note_out(8'h00, hdcsd_pkg::ST_FAIL, 1'b1);
            blob_phase = hdcsd_pkg::PH_DROP;
          end else begin
            keystream  = cfg_salt ^ body_length;
            blob_phase = hdcsd_pkg::PH_PAYLOAD;
          end
        end else if (b.last_in) begin
          note_out(8'h00, hdcsd_pkg::ST_FAIL, 1'b1);
        end
      end
      hdcsd_pkg::PH_PAYLOAD: begin
        idx = {1'b0, blob_pos} - {1'b0, hdcsd_pkg::HEADER_BYTES};
        fin = (idx == body_length - 32'd1);
        keystream = (keystream * KEY_MULT) ^ (idx + body_length);
        note_out(b.data_byte ^ keystream[7:0], hdcsd_pkg::ST_DECRYPT, fin | b.last_in);
        if (fin) blob_phase = hdcsd_pkg::PH_DROP;
      end
      hdcsd_pkg::PH_PASS: note_out(b.data_byte, hdcsd_pkg::ST_PASS, b.last_in);
      default: ;
    endcase
    if (b.last_in) clear_blob_state();
    else if (blob_pos < hdcsd_pkg::COUNT_MAX) blob_pos = blob_pos + 31'd1;
    return ignored;
  endfunction

  function automatic void add_row(logic [7:0] d, logic [30:0] len, logic lst,
                                  bit typed = 1'b0, hdcsd_pkg::out_beat_t want = '0);
    dir_row_t r;
    r.beat  = hdcsd_pkg::in_beat_t'({d, len, lst});
    r.typed = typed;
    r.want  = want;
    directed_rows.push_back(r);
  endfunction

  // four big-endian bytes, last_in on the final one only if asked
  function automatic void add_word(logic [31:0] w, logic [30:0] len, logic lst);
    int k;
    for (k = 3; k >= 0; k--) add_row(w[8*k +: 8], len, (k == 0) ? lst : 1'b0);
  endfunction

  task automatic send_beat(input hdcsd_pkg::in_beat_t b, input bit typed,
                           input hdcsd_pkg::out_beat_t want);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= b;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    if (!decrypt_beat(b)) fed_items++;
    if (typed) pending_out_beats.push_back(want);
    else foreach (beat_outs[i]) pending_out_beats.push_back(beat_outs[i]);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_out_beats.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == hdcsd_pkg::REG_MAGIC) cfg_magic = value;
    else cfg_salt = value;
    @(posedge clk);
  endtask

  task automatic send_blob();
    logic [7:0]          blob[$];
    logic [31:0]         word;
    logic [31:0]         len_field;
    logic [30:0]         blen;
    hdcsd_pkg::in_beat_t b;
    int                  pick;
    int                  total;
    int                  n_pay;
    int                  n_trail;
    int                  k;
    bit                  noisy;
    pick  = $urandom_range(99);
    noisy = 1'b0;
    if (pick < 60) begin
      // correct magic, a length field that may be bad, payload and maybe trailing bytes
      n_pay   = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10, 1);
      n_trail = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
      total   = 8 + n_pay + n_trail;
      blen    = ($urandom_range(6) == 0) ? 31'($urandom) : 31'(total);
      case ($urandom_range(9))
        0: len_field = '0;
        1: len_field = {1'b0, blen} - {1'b0, hdcsd_pkg::HEADER_BYTES} + 32'd1;
        2: len_field = $urandom | 32'h8000_0000;
        3: len_field = {1'b0, blen} - {1'b0, hdcsd_pkg::HEADER_BYTES};
        default: len_field = 32'(n_pay);
      endcase
      for (k = 3; k >= 0; k--) blob.push_back(cfg_magic[8*k +: 8]);
      for (k = 3; k >= 0; k--) blob.push_back(len_field[8*k +: 8]);
      if ($urandom_range(9) == 0) total = $urandom_range(total, 1);
    end else if (pick < 75) begin
      total = $urandom_range(8, 1);
      blen  = 31'($urandom_range(7));
    end else if (pick < 90) begin
      // magic off by one bit
      word = cfg_magic ^ (32'd1 << $urandom_range(31));
      for (k = 3; k >= 0; k--) blob.push_back(word[8*k +: 8]);
      total = $urandom_range(12, 4);
      blen  = 31'($urandom_range(20, 8));
    end else begin
      total = $urandom_range(12, 1);
      blen  = 31'($urandom);
      noisy = 1'b1;
    end
    while (blob.size() < total) blob.push_back(8'($urandom));
    for (k = 0; k < total; k++) begin
      if (k > 0 && $urandom_range(63) == 0) wait_drained();
      b.data_byte   = blob[k];
      b.blob_length = noisy ? 31'($urandom) : blen;
      b.last_in     = (k == total - 1);
      send_beat(b, 1'b0, '0);
    end
  endtask

  initial begin
    int          idle_plan[5]  = '{0, 64, 0, 13, 0};
    int          stall_plan[5] = '{0, 0, 64, 13, 0};
    logic [31:0] magic_plan[5];
    logic [31:0] salt_plan[5];
    int          goal;
    magic_plan = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, hdcsd_pkg::MAGIC_RESET,
                   $urandom};
    salt_plan  = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom, $urandom,
                   hdcsd_pkg::SALT_RESET};
    cfg_magic  = hdcsd_pkg::MAGIC_RESET;
    cfg_salt   = hdcsd_pkg::SALT_RESET;
    clear_blob_state();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // short blob with zero length
    add_row(8'h00, 31'd0, 1'b1, 1'b1,
            hdcsd_pkg::out_beat_t'({8'h00, hdcsd_pkg::ST_PASS, 1'b1}));
    // ends inside the magic bytes
    add_row(8'h52, 31'h7FFF_FFFF, 1'b0);
    add_row(8'h59, 31'h7FFF_FFFF, 1'b1);
    // ends inside the length bytes
    add_word(hdcsd_pkg::MAGIC_RESET, 31'h7FFF_FFFF, 1'b0);
    add_row(8'h80, 31'h7FFF_FFFF, 1'b1, 1'b1,
            hdcsd_pkg::out_beat_t'({8'h00, hdcsd_pkg::ST_FAIL, 1'b1}));
    // one payload byte, then a trailing byte that is dropped
    add_word(hdcsd_pkg::MAGIC_RESET, 31'd10, 1'b0);
    add_word(32'd1, 31'd10, 1'b0);
    add_row(8'h5A, 31'd10, 1'b0);
    add_row(8'hC3, 31'd10, 1'b1);
    // magic mismatch on the last byte, which also ends the blob
    add_word(hdcsd_pkg::MAGIC_RESET ^ 32'd1, 31'd8, 1'b1);
    // length with top bit set fails the unsigned compare
    add_word(hdcsd_pkg::MAGIC_RESET, 31'h7FFF_FFFF, 1'b0);
    add_row(8'h80, 31'h7FFF_FFFF, 1'b0);
    add_row(8'h00, 31'h7FFF_FFFF, 1'b0);
    add_row(8'h00, 31'h7FFF_FFFF, 1'b0);
    add_row(8'hFF, 31'h7FFF_FFFF, 1'b1, 1'b1,
            hdcsd_pkg::out_beat_t'({8'h00, hdcsd_pkg::ST_FAIL, 1'b1}));
    foreach (directed_rows[i])
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

    for (int p = 0; p < 5; p++) begin
      wait_drained();
      repeat (4) @(posedge clk);
      send_idle_pct = idle_plan[p];
      stall_pct     = stall_plan[p];
      write_reg(hdcsd_pkg::REG_MAGIC, magic_plan[p]);
      write_reg(hdcsd_pkg::REG_SALT, salt_plan[p]);
      goal = fed_items + 62;
      while (fed_items < goal) send_blob();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
